/* rtl/imm_pkg.sv */
// shared types, constants and helpers for the integer matrix multiplier
`default_nettype none
package imm_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int DATA_W_DEF  = 32;

  localparam int ELEM_W   = 32;
  localparam int IDX_OUT_W = 3;
  localparam int DIM_W    = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

  typedef struct packed {
    logic                     which_matrix;
    logic signed [ELEM_W-1:0] element;
  } in_item_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] product;
    logic [IDX_OUT_W-1:0]     out_row;
    logic [IDX_OUT_W-1:0]     out_col;
    logic                     last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPUTE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic                 first_k;
    logic                 last_k;
    logic                 last_entry;
    logic [IDX_OUT_W-1:0] row;
    logic [IDX_OUT_W-1:0] col;
  } tag_t;

  typedef struct packed {
    logic wr_left;
    logic wr_right;
    logic issue;
    tag_t tag;
  } dp_cmd_t;

  typedef struct packed {
    logic active;
  } dp_status_t;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] max_dim);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = 4'd1;
    end else if (v > max_dim) begin
      r = max_dim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/imm_ctrl.sv */
// controller: config registers, load counters and the compute sequencer
`default_nettype none
module imm_ctrl import imm_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF,
  localparam int DEPTH  = MAX_DIM * MAX_DIM,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic                 which_matrix,
  output logic                      busy,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data,
  output dp_cmd_t                   cmd,
  output logic [ADDR_W-1:0]         wr_addr,
  output logic [ADDR_W-1:0]         rd_left_addr,
  output logic [ADDR_W-1:0]         rd_right_addr,
  input  wire dp_status_t           status
);

  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  state_t state, state_next;

  logic [DIM_W-1:0] rows_a, inner_dim, cols_b;
  logic [DIM_W-1:0] nr, nk, nc;
  logic [7:0]       lim_left, lim_right;

  logic [CNT_W-1:0] left_count, left_count_next;
  logic [CNT_W-1:0] right_count, right_count_next;

  logic [IDX_W-1:0]  i, i_next, j, j_next, k, k_next;
  logic [ADDR_W-1:0] lbase, lbase_next, raddr, raddr_next;

  logic accept, cfg_we, cfg_hit, left_ok, right_done, go;
  logic last_k, last_col, last_row;

  assign nr = eff_dim(rows_a, DIM_W'(MAX_DIM));
  assign nk = eff_dim(inner_dim, DIM_W'(MAX_DIM));
  assign nc = eff_dim(cols_b, DIM_W'(MAX_DIM));

  assign lim_left  = 8'(nr) * 8'(nk);
  assign lim_right = 8'(nk) * 8'(nc);

  assign accept     = start && (state == ST_IDLE);
  assign cfg_we     = cfg_valid && cfg_ready;
  assign cfg_hit    = cfg_we && (cfg_index == CFG_ROWS_A || cfg_index == CFG_INNER_DIM ||
                                 cfg_index == CFG_COLS_B);
  assign left_ok    = 8'(left_count) < lim_left;
  assign right_done = (8'(right_count) + 8'd1) >= lim_right;
  assign go         = accept && which_matrix && right_done;

  assign last_k   = DIM_W'(k) == (nk - 4'd1);
  assign last_col = DIM_W'(j) == (nc - 4'd1);
  assign last_row = DIM_W'(i) == (nr - 4'd1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (go) state_next = ST_COMPUTE;
      end
      ST_COMPUTE: begin
        if (last_k && last_col && last_row) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status.active) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // load counters
  always_comb begin
    left_count_next  = left_count;
    right_count_next = right_count;
    priority if (cfg_hit) begin
      left_count_next  = '0;
      right_count_next = '0;
    end else if (accept && !which_matrix) begin
      if (left_ok) left_count_next = left_count + CNT_W'(1);
    end else if (accept && which_matrix) begin
      if (right_done) begin
        left_count_next  = '0;
        right_count_next = '0;
      end else begin
        right_count_next = right_count + CNT_W'(1);
      end
    end else begin
      left_count_next = left_count;
    end
  end

  // walk i, j, k with running store addresses
  always_comb begin
    i_next     = i;
    j_next     = j;
    k_next     = k;
    lbase_next = lbase;
    raddr_next = raddr;
    if (go) begin
      i_next     = '0;
      j_next     = '0;
      k_next     = '0;
      lbase_next = '0;
      raddr_next = '0;
    end else if (state == ST_COMPUTE) begin
      if (!last_k) begin
        k_next     = k + IDX_W'(1);
        raddr_next = raddr + ADDR_W'(nc);
      end else begin
        k_next = '0;
        if (last_col) begin
          j_next     = '0;
          raddr_next = '0;
          i_next     = i + IDX_W'(1);
          lbase_next = lbase + ADDR_W'(nk);
        end else begin
          j_next     = j + IDX_W'(1);
          raddr_next = ADDR_W'(j) + ADDR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rows_a      <= DIM_RESET;
      inner_dim   <= DIM_RESET;
      cols_b      <= DIM_RESET;
      left_count  <= '0;
      right_count <= '0;
    end else begin
      state       <= state_next;
      left_count  <= left_count_next;
      right_count <= right_count_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROWS_A:    rows_a    <= cfg_data;
          CFG_INNER_DIM: inner_dim <= cfg_data;
          CFG_COLS_B:    cols_b    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    i     <= i_next;
    j     <= j_next;
    k     <= k_next;
    lbase <= lbase_next;
    raddr <= raddr_next;
  end

  // outputs
  always_comb begin
    busy               = (state != ST_IDLE);
    cfg_ready          = (state == ST_IDLE);
    cmd.wr_left        = accept && !which_matrix && left_ok;
    cmd.wr_right       = accept && which_matrix;
    cmd.issue          = (state == ST_COMPUTE);
    cmd.tag.first_k    = (k == '0);
    cmd.tag.last_k     = last_k;
    cmd.tag.last_entry = last_row && last_col;
    cmd.tag.row        = IDX_OUT_W'(i);
    cmd.tag.col        = IDX_OUT_W'(j);
    wr_addr            = which_matrix ? right_count[ADDR_W-1:0] : left_count[ADDR_W-1:0];
    rd_left_addr       = lbase + ADDR_W'(k);
    rd_right_addr      = raddr;
  end

endmodule
`default_nettype wire

/* rtl/imm_datapath.sv */
// datapath: element stores, multiply pipeline, accumulator and result register
`default_nettype none
module imm_datapath import imm_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF,
  parameter int DATA_W  = DATA_W_DEF,
  localparam int DEPTH  = MAX_DIM * MAX_DIM,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire dp_cmd_t                  cmd,
  input  wire logic [ADDR_W-1:0]        wr_addr,
  input  wire logic signed [ELEM_W-1:0] element,
  input  wire logic [ADDR_W-1:0]        rd_left_addr,
  input  wire logic [ADDR_W-1:0]        rd_right_addr,
  output dp_status_t                    status,
  output logic                          result_valid,
  output out_item_t                     result
);

  logic [DATA_W-1:0] left_mem  [DEPTH];
  logic [DATA_W-1:0] right_mem [DEPTH];
  logic [DATA_W-1:0] wr_data;

  logic [DATA_W-1:0] a_q, b_q;
  tag_t              tag1;
  logic              v1;

  logic [DATA_W-1:0] prod;
  tag_t              tag_m;
  logic              v_m;
  logic              mul_active;

  logic [DATA_W-1:0] acc, acc_next;

  // sign-extend or truncate the incoming element to the arithmetic width
  assign wr_data = DATA_W'(element);

  always_ff @(posedge clk) begin
    if (cmd.wr_left) left_mem[wr_addr] <= wr_data;
    if (cmd.wr_right) right_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      a_q <= left_mem[rd_left_addr];
      b_q <= right_mem[rd_right_addr];
    end
    tag1 <= cmd.tag;
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= cmd.issue;
  end

  if (DATA_W <= 32) begin : g_mul_one
    always_ff @(posedge clk) begin
      if (rst) v_m <= 1'b0;
      else v_m <= v1;
      prod  <= a_q * b_q;
      tag_m <= tag1;
    end
    assign mul_active = 1'b0;
  end else begin : g_mul_split
    localparam int HI_W = DATA_W - 32;
    logic [63:0]     pp0;
    logic [HI_W-1:0] pp1, pp2;
    tag_t            tag2;
    logic            v2;

    // low partial product and the two cross terms, only the low bits survive
    always_ff @(posedge clk) begin
      if (rst) begin
        v2  <= 1'b0;
        v_m <= 1'b0;
      end else begin
        v2  <= v1;
        v_m <= v2;
      end
      pp0   <= a_q[31:0] * b_q[31:0];
      pp1   <= a_q[HI_W-1:0] * b_q[DATA_W-1:32];
      pp2   <= a_q[DATA_W-1:32] * b_q[HI_W-1:0];
      tag2  <= tag1;
      prod  <= pp0[DATA_W-1:0] + {HI_W'(pp1 + pp2), 32'd0};
      tag_m <= tag2;
    end
    assign mul_active = v2;
  end

  assign acc_next = tag_m.first_k ? prod : acc + prod;

  always_ff @(posedge clk) begin
    if (v_m) acc <= acc_next;
    result.product <= ELEM_W'(acc_next);
    result.out_row <= tag_m.row;
    result.out_col <= tag_m.col;
    result.last    <= tag_m.last_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else result_valid <= v_m && tag_m.last_k;
  end

  assign status.active = v1 || mul_active || v_m;

endmodule
`default_nettype wire

/* rtl/integer_matrix_multiply.sv */
// integer matrix multiplier top level: C = A x B over a command-style port
// loading: one element item per cycle, busy stays low while A and B stream in
// the item completing B raises busy; results then pass the fetch, multiply and result registers
// (plus a partial-product register when DATA_W > 32), one per output entry, row-major, never held off
// busy drops once the MAC pipe has drained after the last product
// synchronous reset: dimensions return to 8, load counts to zero, stores keep contents
`default_nettype none
module integer_matrix_multiply import imm_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF,
  parameter int DATA_W  = DATA_W_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire in_item_t             operand,
  output logic                      result_valid,
  output out_item_t                 result,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  dp_cmd_t           cmd;
  dp_status_t        status;
  logic [ADDR_W-1:0] wr_addr, rd_left_addr, rd_right_addr;

  imm_ctrl #(
    .MAX_DIM(MAX_DIM)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .which_matrix (operand.which_matrix),
    .busy         (busy),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .wr_addr      (wr_addr),
    .rd_left_addr (rd_left_addr),
    .rd_right_addr(rd_right_addr),
    .status       (status)
  );

  imm_datapath #(
    .MAX_DIM(MAX_DIM),
    .DATA_W (DATA_W)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .wr_addr      (wr_addr),
    .element      (operand.element),
    .rd_left_addr (rd_left_addr),
    .rd_right_addr(rd_right_addr),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
`default_nettype wire

/* rtl/imm_checker.sv */
// port-level checks for the integer matrix multiplier, bound to the top level
`default_nettype none
module imm_checker import imm_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      busy,
  input wire logic      result_valid,
  input wire out_item_t result,
  input wire logic      cfg_ready
);

  // results only come out during a compute run
  a_result_in_run: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result item outside a compute run");

  // the final entry closes the run
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |=> !result_valid)
    else $error("result item after the final entry");

  // configuration is only taken while idle
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !busy)
    else $error("config port ready during a run");

  // reset leaves the block idle
  a_reset_idle: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (!busy && !result_valid))
    else $error("block not idle after reset");

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (
  .clk         (clk),
  .rst         (rst),
  .busy        (busy),
  .result_valid(result_valid),
  .result      (result),
  .cfg_ready   (cfg_ready)
);
`default_nettype wire

/* verif/integer_matrix_multiply_tb.sv */
// self-checking testbench for the integer matrix multiplier: directed table, largest shapes, then random jobs
`timescale 1ns / 100ps
module integer_matrix_multiply_tb import imm_pkg::*;;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 32;
  localparam int RANDOM_ITEMS  = 250;

  localparam logic MAT_A = 1'b0;
  localparam logic MAT_B = 1'b1;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [DIM_W-1:0]     val;
    in_item_t             item;
    bit                   typed;
    out_item_t            want;
  } step_row_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  in_item_t             operand;
  logic                 result_valid;
  out_item_t            result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;

  // predictor state
  logic [DIM_W-1:0]  dim_rows;
  logic [DIM_W-1:0]  dim_inner;
  logic [DIM_W-1:0]  dim_cols;
  logic [ELEM_W-1:0] a_mem [64];
  logic [ELEM_W-1:0] b_mem [64];
  bit                a_loaded [64];
  int                a_cnt;
  int                b_cnt;

  out_item_t entries_due [$];
  out_item_t due;
  step_row_t directed_rows [$];

  int  n_errors = 0;
  int  n_items = 0;
  int  n_entries = 0;
  int  n_writes = 0;
  int  n_jobs = 0;
  int  cycle_count = 0;
  bit  no_gaps = 0;

  integer_matrix_multiply dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operand      (operand),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // zero acts as one, above the maximum acts as the maximum
  function automatic int dim_of(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
    return int'(v);
  endfunction

  task automatic apply_dim_write(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    case (idx)
      CFG_ROWS_A:    dim_rows = val;
      CFG_INNER_DIM: dim_inner = val;
      CFG_COLS_B:    dim_cols = val;
      default: return;
    endcase
    a_cnt = 0;
    b_cnt = 0;
  endtask

  task automatic predict_matrix_step(in_item_t it);
    int nr;
    int nk;
    int nc;
    logic [ELEM_W-1:0] acc;
    out_item_t e;
    nr = dim_of(dim_rows);
    nk = dim_of(dim_inner);
    nc = dim_of(dim_cols);
    if (it.which_matrix == MAT_A) begin
      // further A elements are dropped once A is full
      if (a_cnt < nr * nk) begin
        a_mem[a_cnt] = it.element;
        a_loaded[a_cnt] = 1'b1;
        a_cnt++;
      end
    end else begin
      b_mem[b_cnt] = it.element;
      b_cnt++;
      if (b_cnt == nk * nc) begin
        for (int i = 0; i < nr; i++) begin
          for (int j = 0; j < nc; j++) begin
            acc = '0;
            for (int k = 0; k < nk; k++) begin
              acc = acc + a_mem[i * nk + k] * b_mem[k * nc + j];
            end
            e.product = acc;
            e.out_row = 3'(i);
            e.out_col = 3'(j);
            e.last = (i == nr - 1) && (j == nc - 1);
            entries_due.insert(entries_due.size(), e);
          end
        end
        a_cnt = 0;
        b_cnt = 0;
      end
    end
  endtask

  task automatic drive_item(in_item_t it, bit typed, out_item_t want);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      @(negedge clk) start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    operand = it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_matrix_step(it);
    if (typed) entries_due[entries_due.size() - 1] = want;
    n_items++;
  endtask

  // writes only once the block has drained all its results
  task automatic write_dim_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    @(negedge clk) start = 1'b0;
    while (entries_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES + $urandom_range(0, 5)) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_dim_write(idx, val);
    n_writes++;
    @(negedge clk) cfg_valid = 1'b0;
  endtask

  task automatic set_dims(logic [DIM_W-1:0] r, logic [DIM_W-1:0] k, logic [DIM_W-1:0] c);
    write_dim_reg(CFG_ROWS_A, r);
    write_dim_reg(CFG_INNER_DIM, k);
    write_dim_reg(CFG_COLS_B, c);
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return '0;
      7: return DIM_W'($urandom_range(4, 8));
      8: return DIM_W'($urandom_range(9, 15));
      9: return DIM_W'($urandom_range(1, 4));
      default: return DIM_W'($urandom_range(1, 3));
    endcase
  endfunction

  function automatic logic [CFG_IDX_W-1:0] pick_reg();
    case ($urandom_range(0, 2))
      0: return CFG_ROWS_A;
      1: return CFG_INNER_DIM;
      default: return CFG_COLS_B;
    endcase
  endfunction

  function automatic logic [ELEM_W-1:0] pick_element();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          default: return 32'h0000_0000;
        endcase
      end
      1, 2, 3: return ELEM_W'($urandom_range(0, 16)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  // one pair of matrices; b_first may leave A short, broken stops early and rewrites a register
  task automatic run_job(bit b_first, bit broken);
    int nr;
    int nk;
    int nc;
    int na;
    int nb;
    int n_a;
    int n_b;
    int drop;
    int cut;
    bit covered;
    bit seq [$];
    in_item_t it;
    out_item_t none;
    nr = dim_of(dim_rows);
    nk = dim_of(dim_inner);
    nc = dim_of(dim_cols);
    na = nr * nk;
    nb = nk * nc;
    none = '0;
    drop = 0;
    covered = 1'b1;
    for (int p = 0; p < na; p++) if (!a_loaded[p]) covered = 1'b0;
    // only leave A short where the missing entries hold earlier data
    if (b_first && covered) drop = $urandom_range(1, na);
    n_a = na - drop;
    n_b = nb - 1;
    while (n_a + n_b > 0) begin
      if ($urandom_range(1, n_a + n_b) <= n_a) begin
        seq.insert(seq.size(), MAT_A);
        n_a--;
      end else begin
        seq.insert(seq.size(), MAT_B);
        n_b--;
      end
    end
    if (drop == 0 && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) seq.insert(seq.size(), MAT_A);
    end
    seq.insert(seq.size(), MAT_B);
    cut = seq.size();
    if (broken) cut = (seq.size() > 1) ? $urandom_range(1, seq.size() - 1) : 0;
    for (int p = 0; p < cut; p++) begin
      it.which_matrix = seq[p];
      it.element = pick_element();
      drive_item(it, 1'b0, none);
    end
    if (broken) write_dim_reg(pick_reg(), pick_dim());
    n_jobs++;
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    step_row_t row;
    row = '{is_cfg: 1'b1, idx: idx, val: val, item: '0, typed: 1'b0, want: '0};
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic add_elem(logic which, logic [ELEM_W-1:0] value);
    step_row_t row;
    row = '{is_cfg: 1'b0, idx: '0, val: '0, item: '0, typed: 1'b0, want: '0};
    row.item.which_matrix = which;
    row.item.element = value;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // closing B element of a 1x1x1 product with its single entry written out
  task automatic add_typed(logic [ELEM_W-1:0] value, logic [ELEM_W-1:0] prod);
    step_row_t row;
    row = '{is_cfg: 1'b0, idx: '0, val: '0, item: '0, typed: 1'b1, want: '0};
    row.item.which_matrix = MAT_B;
    row.item.element = value;
    row.want.product = prod;
    row.want.out_row = '0;
    row.want.out_col = '0;
    row.want.last = 1'b1;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (entries_due.size() == 0) begin
        $error("unexpected result item: row %0d col %0d product %0d",
               result.out_row, result.out_col, result.product);
        n_errors++;
      end else begin
        due = entries_due.pop_front();
        n_entries++;
        if (result.product !== due.product) begin
          $error("product: expected %0d, got %0d", due.product, result.product);
          n_errors++;
        end
        if (result.out_row !== due.out_row) begin
          $error("out_row: expected %0d, got %0d", due.out_row, result.out_row);
          n_errors++;
        end
        if (result.out_col !== due.out_col) begin
          $error("out_col: expected %0d, got %0d", due.out_col, result.out_col);
          n_errors++;
        end
        if (result.last !== due.last) begin
          $error("last: expected %0d, got %0d", due.last, result.last);
          n_errors++;
        end
      end
    end
  end

  initial begin
    int directed_items;
    bit pick_b_first;
    bit pick_broken;
    int mode;
    rst = 1'b1;
    start = 1'b0;
    operand = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    dim_rows = DIM_RESET;
    dim_inner = DIM_RESET;
    dim_cols = DIM_RESET;
    a_cnt = 0;
    b_cnt = 0;
    foreach (a_loaded[p]) a_loaded[p] = 1'b0;

    // zero dimensions act as one: single-entry products at the element extremes
    add_cfg(CFG_ROWS_A, 4'd0);
    add_cfg(CFG_INNER_DIM, 4'd1);
    add_cfg(CFG_COLS_B, 4'd0);
    add_elem(MAT_A, 32'h7fff_ffff);
    add_typed(32'h7fff_ffff, 32'h0000_0001);
    add_elem(MAT_A, 32'h8000_0000);
    add_typed(32'h8000_0000, 32'h0000_0000);
    add_elem(MAT_A, 32'hffff_ffff);
    add_typed(32'h7fff_ffff, 32'h8000_0001);
    // second A element is ignored
    add_elem(MAT_A, 32'd5);
    add_elem(MAT_A, 32'd7);
    add_typed(32'd3, 32'd15);
    // B alone completes, reusing the stored A entry
    add_typed(32'hffff_fffe, 32'hffff_fff6);
    // partial load, then a register write restarts it
    add_cfg(CFG_ROWS_A, 4'd3);
    add_cfg(CFG_COLS_B, 4'd2);
    add_cfg(CFG_INNER_DIM, 4'd2);
    add_elem(MAT_A, 32'd1);
    add_elem(MAT_A, 32'd2);
    add_cfg(CFG_INNER_DIM, 4'd2);
    add_elem(MAT_A, 32'd3);
    add_elem(MAT_A, 32'hffff_fffc);
    add_elem(MAT_B, 32'hffff_ffff);
    add_elem(MAT_A, 32'd5);
    add_elem(MAT_A, 32'h7fff_ffff);
    add_elem(MAT_B, 32'h8000_0000);
    add_elem(MAT_A, 32'hffff_ffff);
    add_elem(MAT_B, 32'd6);
    add_elem(MAT_A, 32'd2);
    add_elem(MAT_B, 32'd7);

    repeat (4) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg) begin
        write_dim_reg(directed_rows[r].idx, directed_rows[r].val);
      end else begin
        drive_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
      end
    end
    directed_items = n_items;

    // largest shapes once each, above-maximum values among them
    set_dims(4'd15, 4'd1, 4'd8);
    run_job(1'b0, 1'b0);
    set_dims(4'd1, 4'd15, 4'd1);
    run_job(1'b0, 1'b0);
    set_dims(4'd8, 4'd8, 4'd8);
    run_job(1'b0, 1'b0);

    while (n_items - directed_items < RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 9) < 3) begin
        if ($urandom_range(0, 1)) write_dim_reg(CFG_ROWS_A, pick_dim());
        if ($urandom_range(0, 1)) write_dim_reg(CFG_INNER_DIM, pick_dim());
        if ($urandom_range(0, 1)) write_dim_reg(CFG_COLS_B, pick_dim());
      end
      mode = $urandom_range(0, 9);
      pick_b_first = (mode == 7);
      pick_broken = (mode >= 8);
      run_job(pick_b_first, pick_broken);
    end

    @(negedge clk) start = 1'b0;
    while (entries_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d element items in %0d matrix jobs with %0d register writes",
             n_items, n_jobs, n_writes);
    $display("checked %0d product entries, %0d mismatches", n_entries, n_errors);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/imm_pkg.sv
rtl/imm_ctrl.sv
rtl/imm_datapath.sv
rtl/integer_matrix_multiply.sv
rtl/imm_checker.sv
verif/integer_matrix_multiply_tb.sv
